>>> hdl/ccsc_pkg.sv
// Shared types, codes and helper functions for the clock calendar set controller.
package ccsc_pkg;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 56;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_MENU = 2'd1,
        MODE_EDIT = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KEY_UP   = 2'd0,
        KEY_DOWN = 2'd1,
        KEY_SET  = 2'd2,
        KEY_OK   = 2'd3
    } key_t;

    typedef enum logic [1:0] {
        COMMIT_NONE      = 2'd0,
        COMMIT_DATE      = 2'd1,
        COMMIT_TIME_DATE = 2'd2
    } commit_t;

    localparam logic [2:0] PAGE_HELP  = 3'd1;
    localparam logic [2:0] PAGE_TIME  = 3'd2;
    localparam logic [2:0] PAGE_DATE  = 3'd3;
    localparam logic [2:0] PAGE_ALARM = 3'd4;

    localparam logic [1:0] FIELD_1 = 2'd1;
    localparam logic [1:0] FIELD_2 = 2'd2;
    localparam logic [1:0] FIELD_3 = 2'd3;

    typedef struct packed {
        mode_t      mode;
        logic [2:0] page;
        logic [1:0] field;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] alm_hours;
        logic [5:0] alm_minutes;
    } state_t;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] alm_hours;
        logic [5:0] alm_minutes;
    } now_t;

    // Wrapping up/down step over lo..hi.
    function automatic logic [6:0] step_val(input logic [6:0] v, input logic [6:0] lo,
                                            input logic [6:0] hi, input logic up);
        logic [6:0] r;
        if (up) begin
            r = (v >= hi) ? lo : v + 7'd1;
        end else begin
            r = (v <= lo || v > hi) ? hi : v - 7'd1;
        end
        return r;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic [6:0] y);
        logic [4:0] r;
        case (m)
            4'd2:                      r = (y[1:0] == 2'd0) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
            default:                   r = 5'd31;
        endcase
        return r;
    endfunction

    // (3 * (m + 1)) / 5
    function automatic logic [3:0] month_term(input logic [3:0] m);
        logic [3:0] r;
        case (m)
            4'd0:          r = 4'd0;
            4'd1, 4'd2:    r = 4'd1;
            4'd3:          r = 4'd2;
            4'd4, 4'd5:    r = 4'd3;
            4'd6, 4'd7:    r = 4'd4;
            4'd8:          r = 4'd5;
            4'd9, 4'd10:   r = 4'd6;
            4'd11, 4'd12:  r = 4'd7;
            4'd13:         r = 4'd8;
            default:       r = 4'd9;
        endcase
        return r;
    endfunction

    // x mod 7 by folding octal digits (8 = 1 mod 7).
    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [4:0] a;
        logic [3:0] b;
        a = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[7:6]);
        b = 4'(a[2:0]) + 4'(a[4:3]);
        return (b >= 4'd7) ? 3'(b - 4'd7) : b[2:0];
    endfunction

endpackage

>>> hdl/ccsc_update.sv
// Next-state logic for one key event: mode/page/field walk, field edit, commit.
module ccsc_update (
    input  ccsc_pkg::state_t  cur,
    input  ccsc_pkg::key_t    key,
    input  ccsc_pkg::now_t    now,
    output ccsc_pkg::state_t  nxt,
    output logic [2:0]        wday,
    output ccsc_pkg::commit_t commit
);

    logic       up;
    logic [4:0] day_max;
    logic [7:0] wsum;

    assign up      = (key == ccsc_pkg::KEY_UP);
    assign day_max = ccsc_pkg::month_len(cur.month, cur.year);

    // year/100 is 0 or 1 for a 7-bit year, year/400 is always 0
    assign wsum = 8'(cur.day) + {3'd0, cur.month, 1'b0}
                + 8'(ccsc_pkg::month_term(cur.month)) + 8'(cur.year)
                + 8'(cur.year[6:2]) - ((cur.year >= 7'd100) ? 8'd1 : 8'd0);

    always_comb begin
        nxt    = cur;
        wday   = 3'd0;
        commit = ccsc_pkg::COMMIT_NONE;
        unique case (cur.mode)
            ccsc_pkg::MODE_MENU: begin
                unique case (key)
                    ccsc_pkg::KEY_UP: begin
                        nxt.page = (cur.page >= ccsc_pkg::PAGE_ALARM) ? ccsc_pkg::PAGE_HELP
                                                                      : cur.page + 3'd1;
                    end
                    ccsc_pkg::KEY_DOWN: begin
                        nxt.page = (cur.page <= ccsc_pkg::PAGE_HELP ||
                                    cur.page > ccsc_pkg::PAGE_ALARM) ? ccsc_pkg::PAGE_ALARM
                                                                     : cur.page - 3'd1;
                    end
                    ccsc_pkg::KEY_OK: begin
                        nxt.mode = ccsc_pkg::MODE_IDLE;
                    end
                    default: begin
                        if (cur.page != ccsc_pkg::PAGE_HELP) begin
                            nxt.mode        = ccsc_pkg::MODE_EDIT;
                            nxt.field       = ccsc_pkg::FIELD_1;
                            nxt.hours       = now.hours;
                            nxt.minutes     = now.minutes;
                            nxt.year        = now.year;
                            nxt.month       = now.month;
                            nxt.day         = now.day;
                            nxt.alm_hours   = now.alm_hours;
                            nxt.alm_minutes = now.alm_minutes;
                        end
                    end
                endcase
            end
            ccsc_pkg::MODE_EDIT: begin
                unique case (key)
                    ccsc_pkg::KEY_SET: begin
                        if (cur.field >= ((cur.page == ccsc_pkg::PAGE_DATE) ? ccsc_pkg::FIELD_3
                                                                          : ccsc_pkg::FIELD_2)) begin
                            nxt.field = ccsc_pkg::FIELD_1;
                        end else begin
                            nxt.field = cur.field + 2'd1;
                        end
                    end
                    ccsc_pkg::KEY_OK: begin
                        wday     = ccsc_pkg::mod7(wsum) + 3'd1;
                        commit   = (cur.hours != now.hours || cur.minutes != now.minutes)
                                 ? ccsc_pkg::COMMIT_TIME_DATE : ccsc_pkg::COMMIT_DATE;
                        nxt.mode = ccsc_pkg::MODE_MENU;
                    end
                    default: begin
                        case (cur.page)
                            ccsc_pkg::PAGE_TIME: begin
                                if (cur.field == ccsc_pkg::FIELD_1) begin
                                    nxt.minutes = 6'(ccsc_pkg::step_val(7'(cur.minutes),
                                                  7'd0, 7'd59, up));
                                end else if (cur.field == ccsc_pkg::FIELD_2) begin
                                    nxt.hours = 5'(ccsc_pkg::step_val(7'(cur.hours),
                                                7'd0, 7'd23, up));
                                end
                            end
                            ccsc_pkg::PAGE_ALARM: begin
                                if (cur.field == ccsc_pkg::FIELD_1) begin
                                    nxt.alm_minutes = 6'(ccsc_pkg::step_val(
                                        7'(cur.alm_minutes), 7'd0, 7'd59, up));
                                end else if (cur.field == ccsc_pkg::FIELD_2) begin
                                    nxt.alm_hours = 5'(ccsc_pkg::step_val(
                                        7'(cur.alm_hours), 7'd0, 7'd23, up));
                                end
                            end
                            ccsc_pkg::PAGE_DATE: begin
                                if (cur.field == ccsc_pkg::FIELD_1) begin
                                    nxt.year = ccsc_pkg::step_val(cur.year, 7'd0, 7'd99, up);
                                end else if (cur.field == ccsc_pkg::FIELD_2) begin
                                    nxt.month = 4'(ccsc_pkg::step_val(7'(cur.month),
                                                7'd1, 7'd12, up));
                                end else if (cur.field == ccsc_pkg::FIELD_3) begin
                                    nxt.day = 5'(ccsc_pkg::step_val(7'(cur.day),
                                              7'd1, 7'(day_max), up));
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                endcase
            end
            default: begin
                nxt.mode = ccsc_pkg::MODE_IDLE;
                if (key == ccsc_pkg::KEY_SET) begin
                    nxt.mode = ccsc_pkg::MODE_MENU;
                    nxt.page = ccsc_pkg::PAGE_HELP;
                end
            end
        endcase
    end

endmodule

>>> hdl/clock_calendar_set_controller_unit.sv
// Top level of the clock calendar set controller: input register, update logic, result register.
// Takes one key request per cycle and returns one result per request: the request is captured
// in an input register at the accepting edge, the update logic runs in the following cycle
// against the held mode, page, field and edit values, and the result is loaded into an output
// register, which drives m_tvalid, once the output is empty or taken. Both registers advance
// whenever the output is empty or taken, so with m_tready high the sustained rate is one
// request per clock. weekday is nonzero and commit_kind is set only on the result of an ok
// key in edit mode.
module clock_calendar_set_controller_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // now_hours, now_minutes, now_year, now_month, now_day, now alarm hours,
    // now alarm minutes, 2'b0
    input  logic [ccsc_pkg::S_TDATA_W-1:0] s_tdata,
    // func
    input  logic [ccsc_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // mode, page, field_sel, edit_hours, edit_minutes, edit_year, edit_month, edit_day,
    // weekday_out, edit alarm hours, edit alarm minutes, commit_kind, 6'b0
    output logic [ccsc_pkg::M_TDATA_W-1:0] m_tdata
);

    logic                           in_valid_reg;
    ccsc_pkg::key_t                 in_key_reg;
    ccsc_pkg::now_t                 in_now_reg;
    ccsc_pkg::now_t                 now_next;
    ccsc_pkg::state_t               state_reg;
    ccsc_pkg::state_t               state_next;
    logic                           out_valid_reg;
    logic [ccsc_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [ccsc_pkg::M_TDATA_W-1:0] out_data_next;
    logic [2:0]                     wday;
    ccsc_pkg::commit_t              commit;
    logic                           advance;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign now_next.hours       = s_tdata[4:0];
    assign now_next.minutes     = s_tdata[10:5];
    assign now_next.year        = s_tdata[17:11];
    assign now_next.month       = s_tdata[21:18];
    assign now_next.day         = s_tdata[26:22];
    assign now_next.alm_hours   = s_tdata[31:27];
    assign now_next.alm_minutes = s_tdata[37:32];

    ccsc_update u_update (
        .cur    (state_reg),
        .key    (in_key_reg),
        .now    (in_now_reg),
        .nxt    (state_next),
        .wday   (wday),
        .commit (commit)
    );

    always_comb begin
        out_data_next = {6'd0, commit, state_next.alm_minutes, state_next.alm_hours, wday,
                         state_next.day, state_next.month, state_next.year,
                         state_next.minutes, state_next.hours, state_next.field,
                         state_next.page, state_next.mode};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{mode: ccsc_pkg::MODE_IDLE, page: ccsc_pkg::PAGE_HELP,
                               field: ccsc_pkg::FIELD_1, hours: 5'd0, minutes: 6'd0,
                               year: 7'd0, month: 4'd1, day: 5'd1, alm_hours: 5'd0,
                               alm_minutes: 6'd0};
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg) begin
                    state_reg <= state_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_key_reg <= ccsc_pkg::key_t'(s_tuser);
            in_now_reg <= now_next;
        end
        if (advance && in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

>>> hdl/ccsc_checker.sv
// Port-level checks for the clock calendar set controller, bound to the top level.
module ccsc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ccsc_pkg::M_TDATA_W-1:0] m_tdata
);

    // a result never claims an unused mode
    a_mode_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == ccsc_pkg::MODE_IDLE ||
                      m_tdata[1:0] == ccsc_pkg::MODE_MENU ||
                      m_tdata[1:0] == ccsc_pkg::MODE_EDIT))
        else $error("result mode out of range");

    a_page_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[4:2] >= ccsc_pkg::PAGE_HELP &&
                      m_tdata[4:2] <= ccsc_pkg::PAGE_ALARM))
        else $error("result page out of range");

    // a commit always drops back to the menu
    a_commit_menu: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[49:48] != ccsc_pkg::COMMIT_NONE) |->
            (m_tdata[1:0] == ccsc_pkg::MODE_MENU))
        else $error("commit outside menu");

    // weekday is shown exactly on commit results
    a_wday_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[36:34] != 3'd0) ==
                      (m_tdata[49:48] != ccsc_pkg::COMMIT_NONE)))
        else $error("weekday and commit disagree");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind clock_calendar_set_controller_unit ccsc_checker u_ccsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
